// ===== rtl/evt_pkg.sv =====
// ----------------------------------------------------------------------------
// evt_pkg : shared types, constants and table builders
// Point and payload types, register indexes, saturation and the sine table
// generator used at elaboration by the vertex transform.
// ----------------------------------------------------------------------------
package evt_pkg;

   localparam int ANGLE_STEPS = 360;
   localparam int ANGLE_W     = 10;
   localparam int IDX_W       = $clog2(ANGLE_STEPS);
   localparam int COORD_W     = 32;
   localparam int TRIG_W      = 16;
   localparam int CSR_W       = 32;
   localparam int CSR_IDX_W   = 3;

   localparam logic [63:0] Q30_PI      = 64'd3373259426;
   localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;

   localparam logic signed [COORD_W-1:0] SCALE_RESET = 32'sd65536;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_LOCAL_ANGLES  = 3'd0,
      REG_GLOBAL_ANGLES = 3'd1,
      REG_SCALE_X       = 3'd2,
      REG_SCALE_Y       = 3'd3,
      REG_SCALE_Z       = 3'd4,
      REG_OFFSET_X      = 3'd5,
      REG_OFFSET_Y      = 3'd6,
      REG_OFFSET_Z      = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic                      action;
      logic signed [COORD_W-1:0] in_x;
      logic signed [COORD_W-1:0] in_y;
      logic signed [COORD_W-1:0] in_z;
      logic                      last_item;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] out_x;
      logic signed [COORD_W-1:0] out_y;
      logic signed [COORD_W-1:0] out_z;
      logic                      last_out;
   } rsp_type;

   // point as it travels down the pipe
   typedef struct packed {
      logic                      normal;
      logic                      last;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } pt_type;

   // per-axis rotation setting, looked up when the angle register is written
   typedef struct packed {
      logic                     skip;
      logic signed [TRIG_W-1:0] sin_val;
      logic signed [TRIG_W-1:0] cos_val;
   } trig_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] sx;
      logic signed [COORD_W-1:0] sy;
      logic signed [COORD_W-1:0] sz;
      logic signed [COORD_W-1:0] ox;
      logic signed [COORD_W-1:0] oy;
      logic signed [COORD_W-1:0] oz;
   } scl_type;

   typedef logic signed [TRIG_W-1:0] trig_tab_type [ANGLE_STEPS];

   function automatic logic signed [COORD_W-1:0] sat32(input logic signed [64:0] v);
      if (v > 65'sd2147483647) return 32'sh7fffffff;
      else if (v < -65'sd2147483648) return 32'sh80000000;
      return v[COORD_W-1:0];
   endfunction

   // wrap a signed 10-bit degree angle into 0..359
   function automatic logic [IDX_W-1:0] wrap_angle(input logic [ANGLE_W-1:0] ang);
      logic signed [ANGLE_W:0] s;
      s = (ANGLE_W+1)'(signed'(ang));
      if (s < 0) s = s + 11'sd360;
      if (s < 0) s = s + 11'sd360;
      if (s >= 11'sd360) s = s - 11'sd360;
      return s[IDX_W-1:0];
   endfunction

   // one Taylor term step: divide by (2n)(2n+1)
   function automatic logic [63:0] taylor_div(input logic [63:0] t, input int n);
      case (n)
         1:  return t / 64'd6;
         2:  return t / 64'd20;
         3:  return t / 64'd42;
         4:  return t / 64'd72;
         5:  return t / 64'd110;
         6:  return t / 64'd156;
         7:  return t / 64'd210;
         8:  return t / 64'd272;
         9:  return t / 64'd342;
         10: return t / 64'd420;
         11: return t / 64'd506;
         12: return t / 64'd600;
         13: return t / 64'd702;
         14: return t / 64'd812;
         15: return t / 64'd930;
         16: return t / 64'd1056;
         17: return t / 64'd1190;
         18: return t / 64'd1332;
         default: return t / 64'd1482;
      endcase
   endfunction

   // sine of a Q30 angle in [0, 2pi), Q.frac result
   function automatic logic signed [TRIG_W-1:0] table_sine(input logic [63:0] a_in,
                                                          input int frac);
      logic [63:0]        a;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic signed [63:0] r;
      logic               neg;
      a   = a_in;
      neg = 1'b0;
      if (a >= Q30_PI) begin
         a   = a - Q30_PI;
         neg = 1'b1;
      end
      if (a > Q30_HALF_PI) a = Q30_PI - a;
      x2   = (a * a) >> 30;
      term = a;
      sum  = signed'(a);
      for (int n = 1; n < 20; n++) begin
         if (term != 64'd0) begin
            term = taylor_div((term * x2) >> 30, n);
            if (n % 2 == 1) sum = sum - signed'(term);
            else sum = sum + signed'(term);
         end
      end
      if (sum < 0) sum = 64'sd0;
      r = signed'(((unsigned'(sum) << frac) + (64'd1 << 29)) >> 30);
      if (neg) r = -r;
      if (r > 64'sd32767) r = 64'sd32767;
      if (r < -64'sd32768) r = -64'sd32768;
      return r[TRIG_W-1:0];
   endfunction

   function automatic trig_tab_type build_trig(input int frac, input bit cosine);
      trig_tab_type t;
      logic [63:0]  a;
      for (int i = 0; i < ANGLE_STEPS; i++) begin
         a = (((64'(i) * 64'd1745) << 30) + 64'd50000) / 64'd100000;
         if (cosine) a = a + Q30_HALF_PI;
         if (a >= 2 * Q30_PI) a = a - 2 * Q30_PI;
         t[i] = table_sine(a, frac);
      end
      return t;
   endfunction

endpackage

// ===== rtl/evt_req_if.sv =====
// ----------------------------------------------------------------------------
// evt_req_if : input point channel
// Valid/ready channel carrying one point per transaction.
// ----------------------------------------------------------------------------
interface evt_req_if import evt_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/evt_rsp_if.sv =====
// ----------------------------------------------------------------------------
// evt_rsp_if : result point channel
// Valid/ready channel carrying one transformed point per transaction.
// ----------------------------------------------------------------------------
interface evt_rsp_if import evt_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/evt_rot.sv =====
// ----------------------------------------------------------------------------
// evt_rot : one axis rotation, two pipeline stages
// Stage 1 registers the four products, stage 2 sums, rounds and saturates.
// ----------------------------------------------------------------------------
module evt_rot import evt_pkg::*; #(
   parameter int TRIG_FRAC_BITS = 14,
   parameter int AXIS           = 0
) (
   input  logic     clock,
   input  logic     reset,
   input  trig_type trig,
   input  logic     up_valid,
   output logic     up_ready,
   input  pt_type   up_data,
   output logic     dn_valid,
   input  logic     dn_ready,
   output pt_type   dn_data
);

   localparam int PW = COORD_W + TRIG_W;
   localparam int SW = PW + 2;
   localparam logic signed [SW-1:0] HALF = SW'(1) <<< (TRIG_FRAC_BITS - 1);

   logic                      v1_ff, v2_ff;
   pt_type                    d1_ff, d2_ff, d2_in;
   logic signed [PW-1:0]      uc_ff, vs_ff, us_ff, vc_ff;
   logic signed [PW-1:0]      uc_in, vs_in, us_in, vc_in;
   logic signed [COORD_W-1:0] u, v;
   logic signed [SW-1:0]      du, dv;
   logic signed [COORD_W-1:0] nu, nv;
   logic                      adv1, adv2;

   // stall chain
   assign adv2     = !v2_ff || dn_ready;
   assign adv1     = !v1_ff || adv2;
   assign up_ready = adv1;

   // pick the pair that turns about this axis
   always_comb begin
      if (AXIS == 0) begin
         u = up_data.y;
         v = up_data.z;
      end else if (AXIS == 1) begin
         u = up_data.z;
         v = up_data.x;
      end else begin
         u = up_data.x;
         v = up_data.y;
      end
      uc_in = PW'(u) * PW'(trig.cos_val);
      vs_in = PW'(v) * PW'(trig.sin_val);
      us_in = PW'(u) * PW'(trig.sin_val);
      vc_in = PW'(v) * PW'(trig.cos_val);
   end

   // sum, round half up, saturate
   always_comb begin
      du    = SW'(uc_ff) - SW'(vs_ff) + HALF;
      dv    = SW'(us_ff) + SW'(vc_ff) + HALF;
      nu    = sat32(65'(du >>> TRIG_FRAC_BITS));
      nv    = sat32(65'(dv >>> TRIG_FRAC_BITS));
      d2_in = d1_ff;
      if (!trig.skip) begin
         if (AXIS == 0) begin
            d2_in.y = nu;
            d2_in.z = nv;
         end else if (AXIS == 1) begin
            d2_in.z = nu;
            d2_in.x = nv;
         end else begin
            d2_in.x = nu;
            d2_in.y = nv;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= up_valid;
         if (adv2) v2_ff <= v1_ff;
      end
      if (adv1) begin
         d1_ff <= up_data;
         uc_ff <= uc_in;
         vs_ff <= vs_in;
         us_ff <= us_in;
         vc_ff <= vc_in;
      end
      if (adv2) d2_ff <= d2_in;
   end

   assign dn_valid = v2_ff;
   assign dn_data  = d2_ff;

endmodule

// ===== rtl/evt_scl.sv =====
// ----------------------------------------------------------------------------
// evt_scl : scale and offset, three pipeline stages
// Multiply, round and saturate, then saturating offset add. Normals pass.
// ----------------------------------------------------------------------------
module evt_scl import evt_pkg::*; #(
   parameter int COORD_FRAC_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  scl_type cfg,
   input  logic    up_valid,
   output logic    up_ready,
   input  pt_type  up_data,
   output logic    dn_valid,
   input  logic    dn_ready,
   output pt_type  dn_data
);

   localparam int PW = 2 * COORD_W;
   localparam logic signed [PW:0] HALF = (PW+1)'(1) <<< (COORD_FRAC_BITS - 1);

   logic                 v1_ff, v2_ff, v3_ff;
   pt_type               d1_ff, d2_ff, d3_ff, d2_in, d3_in;
   logic signed [PW-1:0] px_ff, py_ff, pz_ff;
   logic                 adv1, adv2, adv3;

   assign adv3     = !v3_ff || dn_ready;
   assign adv2     = !v2_ff || adv3;
   assign adv1     = !v1_ff || adv2;
   assign up_ready = adv1;

   // round and saturate the products
   always_comb begin
      d2_in = d1_ff;
      if (!d1_ff.normal) begin
         d2_in.x = sat32(65'(((PW+1)'(px_ff) + HALF) >>> COORD_FRAC_BITS));
         d2_in.y = sat32(65'(((PW+1)'(py_ff) + HALF) >>> COORD_FRAC_BITS));
         d2_in.z = sat32(65'(((PW+1)'(pz_ff) + HALF) >>> COORD_FRAC_BITS));
      end
   end

   // offset add
   always_comb begin
      d3_in = d2_ff;
      if (!d2_ff.normal) begin
         d3_in.x = sat32(65'(d2_ff.x) + 65'(cfg.ox));
         d3_in.y = sat32(65'(d2_ff.y) + 65'(cfg.oy));
         d3_in.z = sat32(65'(d2_ff.z) + 65'(cfg.oz));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= up_valid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
      end
      if (adv1) begin
         d1_ff <= up_data;
         px_ff <= PW'(up_data.x) * PW'(cfg.sx);
         py_ff <= PW'(up_data.y) * PW'(cfg.sy);
         pz_ff <= PW'(up_data.z) * PW'(cfg.sz);
      end
      if (adv2) d2_ff <= d2_in;
      if (adv3) d3_ff <= d3_in;
   end

   assign dn_valid = v3_ff;
   assign dn_data  = d3_ff;

endmodule

// ===== rtl/euler_vertex_transform.sv =====
// ----------------------------------------------------------------------------
// euler_vertex_transform : Euler-angle point transform
// Local X/Y/Z rotation, scale and offset, then global X/Y/Z rotation.
// ----------------------------------------------------------------------------
//  channel | direction | transaction
//  req_if  | in        | action, in_x, in_y, in_z, last_item
//  rsp_if  | out       | out_x, out_y, out_z, last_out
//  csr_*   | in        | write enable, register index, 32-bit data
//
//  One point per cycle while the output accepts; six rotations of two stages,
//  three stages of scale and offset, set by the multiply / round split.
//  Sine and cosine are looked up once when an angle register is written.
//  Synchronous reset empties the pipe and loads the register defaults.
//  Every stage holds under backpressure; bubbles are squeezed out.
// ----------------------------------------------------------------------------
module euler_vertex_transform import evt_pkg::*; #(
   parameter int COORD_FRAC_BITS = 16,
   parameter int TRIG_FRAC_BITS  = 14
) (
   input  logic                 clock,
   input  logic                 reset,
   evt_req_if.sink              req_if,
   evt_rsp_if.source            rsp_if,
   input  logic                 csr_wen,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   localparam trig_tab_type SIN_TAB = build_trig(TRIG_FRAC_BITS, 1'b0);
   localparam trig_tab_type COS_TAB = build_trig(TRIG_FRAC_BITS, 1'b1);
   localparam int NROT = 6;

   trig_type trig_ff [NROT];
   trig_type trig_in [NROT];
   scl_type  scl_ff, scl_in;

   function automatic trig_type look_up(input logic [ANGLE_W-1:0] ang);
      trig_type         t;
      logic [IDX_W-1:0] idx;
      idx       = wrap_angle(ang);
      t.skip    = (ang == '0);
      t.sin_val = SIN_TAB[idx];
      t.cos_val = COS_TAB[idx];
      return t;
   endfunction

   // register writes
   always_comb begin
      trig_in = trig_ff;
      scl_in  = scl_ff;
      if (csr_wen) begin
         unique case (reg_index_type'(csr_index))
            REG_LOCAL_ANGLES: begin
               for (int k = 0; k < 3; k++)
                  trig_in[k] = look_up(csr_wdata[k*ANGLE_W +: ANGLE_W]);
            end
            REG_GLOBAL_ANGLES: begin
               for (int k = 0; k < 3; k++)
                  trig_in[k+3] = look_up(csr_wdata[k*ANGLE_W +: ANGLE_W]);
            end
            REG_SCALE_X:  scl_in.sx = signed'(csr_wdata);
            REG_SCALE_Y:  scl_in.sy = signed'(csr_wdata);
            REG_SCALE_Z:  scl_in.sz = signed'(csr_wdata);
            REG_OFFSET_X: scl_in.ox = signed'(csr_wdata);
            REG_OFFSET_Y: scl_in.oy = signed'(csr_wdata);
            REG_OFFSET_Z: scl_in.oz = signed'(csr_wdata);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NROT; k++) trig_ff[k] <= '{skip: 1'b1, default: '0};
         scl_ff <= '{sx: SCALE_RESET, sy: SCALE_RESET, sz: SCALE_RESET, default: '0};
      end else begin
         trig_ff <= trig_in;
         scl_ff  <= scl_in;
      end
   end

   // pipeline links: 0..2 local rotations, 3 scale, 4..6 global rotations
   logic   lv [8];
   logic   lr [8];
   pt_type ld [8];

   assign lv[0]        = req_if.valid;
   assign req_if.ready = lr[0];
   assign ld[0]        = '{normal: req_if.data.action, last: req_if.data.last_item,
                           x: req_if.data.in_x, y: req_if.data.in_y,
                           z: req_if.data.in_z};

   for (genvar g = 0; g < 3; g++) begin : g_local
      evt_rot #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS), .AXIS(g)) u_rot (
         .clock(clock), .reset(reset), .trig(trig_ff[g]),
         .up_valid(lv[g]), .up_ready(lr[g]), .up_data(ld[g]),
         .dn_valid(lv[g+1]), .dn_ready(lr[g+1]), .dn_data(ld[g+1])
      );
   end

   evt_scl #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_scl (
      .clock(clock), .reset(reset), .cfg(scl_ff),
      .up_valid(lv[3]), .up_ready(lr[3]), .up_data(ld[3]),
      .dn_valid(lv[4]), .dn_ready(lr[4]), .dn_data(ld[4])
   );

   for (genvar g = 0; g < 3; g++) begin : g_global
      evt_rot #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS), .AXIS(g)) u_rot (
         .clock(clock), .reset(reset), .trig(trig_ff[g+3]),
         .up_valid(lv[g+4]), .up_ready(lr[g+4]), .up_data(ld[g+4]),
         .dn_valid(lv[g+5]), .dn_ready(lr[g+5]), .dn_data(ld[g+5])
      );
   end

   assign rsp_if.valid = lv[7];
   assign lr[7]        = rsp_if.ready;
   assign rsp_if.data  = '{out_x: ld[7].x, out_y: ld[7].y, out_z: ld[7].z,
                           last_out: ld[7].last};

endmodule

// ===== test/tb_euler_vertex_transform.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_euler_vertex_transform : self-checking bench for the point transform
// Drives vertex and normal points through the valid/ready channels. Each
// point accepted at the input is predicted from a local copy of the angle,
// scale and offset registers and of the sine and cosine tables. Each result
// is checked in order against the oldest prediction. Both channels idle and
// stall at random, and the registers are reprogrammed between phases.
// ----------------------------------------------------------------------------
module tb_euler_vertex_transform;
   import evt_pkg::*;

   localparam int          HALF_PERIOD = 6;
   localparam int          STALL_LIMIT = 5000;
   localparam int          DRAIN_WAIT  = 24;
   localparam longint unsigned PI_Q30      = 64'd3373259426;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   logic                 clock;
   logic                 reset;
   logic                 csr_wen;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   evt_req_if req_if ();
   evt_rsp_if rsp_if ();

   euler_vertex_transform uut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // local copy of the register file and trig tables
   logic [29:0] local_rot;
   logic [29:0] global_rot;
   longint      scale_v [3];
   longint      offset_v [3];
   longint      sin_tab [ANGLE_STEPS];
   longint      cos_tab [ANGLE_STEPS];

   rsp_type     expected_points [$];
   int          error_count;
   int          hold_request;
   bit          sender_busy_free;
   bit          receiver_busy_free;

   // clock
   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------
   function automatic longint sine_q14(input longint unsigned a_in);
      longint unsigned a;
      longint unsigned x2;
      longint unsigned term;
      longint          sum;
      longint          r;
      bit              neg;
      a   = a_in;
      neg = 1'b0;
      if (a >= PI_Q30) begin
         a   = a - PI_Q30;
         neg = 1'b1;
      end
      if (a > HALF_PI_Q30) a = PI_Q30 - a;
      x2   = (a * a) >> 30;
      term = a;
      sum  = longint'(a);
      for (int n = 1; n < 20; n++) begin
         if (term != 0) begin
            term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) sum = sum - longint'(term);
            else sum = sum + longint'(term);
         end
      end
      if (sum < 0) sum = 0;
      r = longint'(((unsigned'(sum) << 14) + (64'd1 << 29)) >> 30);
      if (neg) r = -r;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r;
   endfunction

   function automatic void fill_tables();
      longint unsigned a;
      longint unsigned b;
      for (int i = 0; i < ANGLE_STEPS; i++) begin
         a = ((64'(i) * 1745 << 30) + 50000) / 100000;
         b = a + HALF_PI_Q30;
         while (a >= 2 * PI_Q30) a = a - 2 * PI_Q30;
         while (b >= 2 * PI_Q30) b = b - 2 * PI_Q30;
         sin_tab[i] = sine_q14(a);
         cos_tab[i] = sine_q14(b);
      end
   endfunction

   function automatic longint clamp32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // floor of (v + half) >> k, i.e. round half towards plus infinity
   function automatic longint round_shift(input longint v, input int k);
      return (v + (64'sd1 <<< (k - 1))) >>> k;
   endfunction

   function automatic void turn_pair(inout longint u, inout longint v,
                                     input logic [9:0] ang);
      longint a;
      longint c;
      longint s;
      longint nu;
      a = longint'(signed'(ang));
      if (a == 0) return;
      if (a < 0) a += ANGLE_STEPS;
      if (a < 0) a += ANGLE_STEPS;
      if (a >= ANGLE_STEPS) a -= ANGLE_STEPS;
      c  = cos_tab[a];
      s  = sin_tab[a];
      nu = clamp32(round_shift(u * c - v * s, 14));
      v  = clamp32(round_shift(u * s + v * c, 14));
      u  = nu;
   endfunction

   function automatic void turn_xyz(inout longint p [3], input logic [29:0] ang);
      turn_pair(p[1], p[2], ang[9:0]);
      turn_pair(p[2], p[0], ang[19:10]);
      turn_pair(p[0], p[1], ang[29:20]);
   endfunction

   function automatic rsp_type transform_point(input req_type q);
      longint  p [3];
      rsp_type r;
      p[0] = longint'(q.in_x);
      p[1] = longint'(q.in_y);
      p[2] = longint'(q.in_z);
      turn_xyz(p, local_rot);
      if (!q.action) begin
         for (int i = 0; i < 3; i++)
            p[i] = clamp32(round_shift(p[i] * scale_v[i], 16));
         for (int i = 0; i < 3; i++)
            p[i] = clamp32(p[i] + offset_v[i]);
      end
      turn_xyz(p, global_rot);
      r.out_x    = p[0][31:0];
      r.out_y    = p[1][31:0];
      r.out_z    = p[2][31:0];
      r.last_out = q.last_item;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Register writes (only while the pipe is empty)
   // ---------------------------------------------------------------------
   task automatic drain_pipe();
      req_if.valid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [31:0] v);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_wen   <= 1'b0;
      case (idx)
         REG_LOCAL_ANGLES:  local_rot   = v[29:0];
         REG_GLOBAL_ANGLES: global_rot  = v[29:0];
         REG_SCALE_X:       scale_v[0]  = longint'(signed'(v));
         REG_SCALE_Y:       scale_v[1]  = longint'(signed'(v));
         REG_SCALE_Z:       scale_v[2]  = longint'(signed'(v));
         REG_OFFSET_X:      offset_v[0] = longint'(signed'(v));
         REG_OFFSET_Y:      offset_v[1] = longint'(signed'(v));
         default:           offset_v[2] = longint'(signed'(v));
      endcase
   endtask

   task automatic program_all(input logic [29:0] la, input logic [29:0] ga,
                              input logic [31:0] sx, input logic [31:0] sy,
                              input logic [31:0] sz, input logic [31:0] ox,
                              input logic [31:0] oy, input logic [31:0] oz);
      drain_pipe();
      write_reg(REG_LOCAL_ANGLES, {2'b00, la});
      write_reg(REG_GLOBAL_ANGLES, {2'b00, ga});
      write_reg(REG_SCALE_X, sx);
      write_reg(REG_SCALE_Y, sy);
      write_reg(REG_SCALE_Z, sz);
      write_reg(REG_OFFSET_X, ox);
      write_reg(REG_OFFSET_Y, oy);
      write_reg(REG_OFFSET_Z, oz);
   endtask

   // ---------------------------------------------------------------------
   // Sender: one transaction, then at times a random gap
   // ---------------------------------------------------------------------
   task automatic send_point(input req_type q);
      int roll;
      int gap;
      req_if.valid <= 1'b1;
      req_if.data  <= q;
      do @(posedge clock); while (!req_if.ready);
      expected_points.push_back(transform_point(q));
      roll = $urandom_range(0, 99);
      gap  = 0;
      if (!sender_busy_free) begin
         if (roll >= 96) gap = $urandom_range(10, 40);
         else if (roll >= 70) gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic idle_input();
      req_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] rand_coord();
      int pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0:       return 32'h7fffffff;
         1:       return 32'h80000000;
         2, 3:    return $urandom_range(0, 32'h0003ffff) - 32'h00020000;
         4:       return $urandom_range(0, 32'h0fffffff) - 32'h08000000;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type rand_point();
      req_type q;
      q.action    = 1'($urandom_range(0, 1));
      q.in_x      = rand_coord();
      q.in_y      = rand_coord();
      q.in_z      = rand_coord();
      q.last_item = ($urandom_range(0, 7) == 0);
      return q;
   endfunction

   function automatic req_type make_point(input logic act, input logic [31:0] x,
                                          input logic [31:0] y, input logic [31:0] z,
                                          input logic lst);
      req_type q;
      q.action    = act;
      q.in_x      = x;
      q.in_y      = y;
      q.in_z      = z;
      q.last_item = lst;
      return q;
   endfunction

   function automatic logic [29:0] rand_angles();
      logic [9:0] a [3];
      for (int i = 0; i < 3; i++) begin
         case ($urandom_range(0, 5))
            0:       a[i] = 10'd0;
            1:       a[i] = 10'h200;
            2:       a[i] = 10'h1ff;
            default: a[i] = 10'($urandom_range(0, 1023));
         endcase
      end
      return {a[2], a[1], a[0]};
   endfunction

   function automatic logic [31:0] rand_scale();
      case ($urandom_range(0, 5))
         0:       return 32'h7fffffff;
         1:       return 32'h80000000;
         2:       return 32'h00010000;
         default: return $urandom_range(0, 32'h0007ffff) - 32'h00040000;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Receiver: checks each result and drives ready
   // ---------------------------------------------------------------------
   task automatic report(input string what, input logic [31:0] got,
                         input logic [31:0] want);
      if (error_count < 30)
         $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
      error_count++;
   endtask

   initial begin : receiver
      rsp_type want;
      int      stall_left;
      int      roll;
      stall_left = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            if (expected_points.size() == 0) begin
               report("unexpected transaction", rsp_if.data.out_x, 32'h0);
            end else begin
               want = expected_points.pop_front();
               if (rsp_if.data.out_x !== want.out_x)
                  report("out_x", rsp_if.data.out_x, want.out_x);
               if (rsp_if.data.out_y !== want.out_y)
                  report("out_y", rsp_if.data.out_y, want.out_y);
               if (rsp_if.data.out_z !== want.out_z)
                  report("out_z", rsp_if.data.out_z, want.out_z);
               if (rsp_if.data.last_out !== want.last_out)
                  report("last_out", 32'(rsp_if.data.last_out), 32'(want.last_out));
            end
         end
         // long hold-off requested by a test
         if (hold_request > 0) begin
            stall_left   = hold_request;
            hold_request = 0;
         end
         if (reset) begin
            rsp_if.ready <= 1'b0;
         end else if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else if (receiver_busy_free) begin
            rsp_if.ready <= 1'b1;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll >= 97) stall_left = $urandom_range(8, 40);
            else if (roll >= 75) stall_left = $urandom_range(0, 3);
            rsp_if.ready <= (stall_left == 0);
         end
      end
   end

   // watchdog: cycles with work pending but no transaction on either side
   initial begin : watchdog
      int stuck;
      stuck = 0;
      forever begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            stuck = 0;
         else if (req_if.valid || expected_points.size() != 0)
            stuck++;
         if (stuck >= STALL_LIMIT) begin
            $display("tb_euler_vertex_transform: errors");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   task automatic test_reset_defaults();
      send_point(make_point(1'b0, 32'h7fffffff, 32'h80000000, 32'h0, 1'b0));
      send_point(make_point(1'b1, 32'h80000000, 32'h7fffffff, 32'hffffffff, 1'b1));
      send_point(make_point(1'b0, 32'h00010000, 32'hffff8000, 32'h00000001, 1'b0));
   endtask

   task automatic test_angle_cases();
      // negative angles wrapping once and twice, above 359, exactly 360
      program_all({10'h3ff, 10'h200, 10'd360}, {10'd359, 10'h1ff, 10'd90},
                  32'h00010000, 32'h00010000, 32'h00010000, 32'h0, 32'h0, 32'h0);
      for (int i = 0; i < 4; i++) send_point(rand_point());
      send_point(make_point(1'b1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b1));
      send_point(make_point(1'b0, 32'h80000000, 32'h80000000, 32'h80000000, 1'b0));
   endtask

   task automatic test_scale_offset_extremes();
      // saturation in scale and in the offset add
      program_all(30'd0, 30'd0, 32'h7fffffff, 32'h80000000, 32'h0,
                  32'h7fffffff, 32'h80000000, 32'h00008000);
      send_point(make_point(1'b0, 32'h7fffffff, 32'h7fffffff, 32'h12345678, 1'b0));
      send_point(make_point(1'b0, 32'h80000000, 32'h00000001, 32'h80000000, 1'b1));
      send_point(make_point(1'b1, 32'h7fffffff, 32'h80000000, 32'h00010000, 1'b0));
      program_all({10'd45, 10'd30, 10'd60}, {10'h3d3, 10'd180, 10'd270},
                  32'h80000000, 32'h7fffffff, 32'hffff0000,
                  32'h80000000, 32'h7fffffff, 32'hffffffff);
      for (int i = 0; i < 6; i++) send_point(rand_point());
   endtask

   task automatic test_random_phases();
      for (int ph = 0; ph < 7; ph++) begin
         program_all(rand_angles(), rand_angles(), rand_scale(), rand_scale(),
                     rand_scale(), rand_coord(), rand_coord(), rand_coord());
         sender_busy_free   = (ph == 2);
         receiver_busy_free = (ph == 2 || ph == 5);
         for (int i = 0; i < 180; i++) send_point(rand_point());
         sender_busy_free   = 1'b0;
         receiver_busy_free = 1'b0;
      end
   endtask

   task automatic test_backpressure();
      // receiver holds off while the sender keeps offering
      program_all(rand_angles(), rand_angles(), rand_scale(), rand_scale(),
                  rand_scale(), rand_coord(), rand_coord(), rand_coord());
      hold_request     = 300;
      sender_busy_free = 1'b1;
      for (int i = 0; i < 80; i++) send_point(rand_point());
      sender_busy_free = 1'b0;
      // sender pauses until every result is back
      idle_input();
      drain_pipe();
      for (int i = 0; i < 40; i++) send_point(rand_point());
   endtask

   initial begin : main
      reset        = 1'b1;
      csr_wen      = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      req_if.valid = 1'b0;
      req_if.data  = '0;
      error_count  = 0;
      hold_request = 0;
      sender_busy_free   = 1'b0;
      receiver_busy_free = 1'b0;
      local_rot    = '0;
      global_rot   = '0;
      for (int i = 0; i < 3; i++) begin
         scale_v[i]  = 65536;
         offset_v[i] = 0;
      end
      fill_tables();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_angle_cases();
      test_scale_offset_extremes();
      test_random_phases();
      test_backpressure();

      idle_input();
      drain_pipe();
      if (error_count == 0) begin
         $display("tb_euler_vertex_transform: clean");
      end else begin
         $display("tb_euler_vertex_transform: errors");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/evt_pkg.sv
rtl/evt_req_if.sv
rtl/evt_rsp_if.sv
rtl/evt_rot.sv
rtl/evt_scl.sv
rtl/euler_vertex_transform.sv
test/tb_euler_vertex_transform.sv
